/* sv/hvts_pkg.sv */
// Package for the histogram valley threshold search.
// Holds the item, result, configuration and search state types and constants.
// No dependencies.
package hvts_pkg;

	// histogram geometry
	localparam int unsigned BIN_COUNT = 128;
	localparam int unsigned BIN_IDX_W = $clog2(BIN_COUNT);

	// field widths
	localparam int unsigned COUNT_W = 20;
	localparam int unsigned RUN_W   = 7;
	localparam int unsigned THR_W   = 8;
	localparam int unsigned CNT8_W  = 8;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_VALLEY_LEVEL      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN           = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_THRESHOLD = 2'd2;
	localparam int unsigned CFG_DATA_W = COUNT_W;

	// reset values of the configuration registers
	localparam logic [COUNT_W-1:0] VALLEY_LEVEL_RST      = 20'd100;
	localparam logic [RUN_W-1:0]   MIN_RUN_RST           = 7'd3;
	localparam logic [THR_W-1:0]   DEFAULT_THRESHOLD_RST = 8'd115;

	// saturation limits
	localparam logic [CNT8_W-1:0]    CNT8_MAX    = {CNT8_W{1'b1}};
	localparam logic [BIN_IDX_W-1:0] BIN_IDX_MAX = BIN_IDX_W'(BIN_COUNT - 1);

	typedef struct packed {
		logic [COUNT_W-1:0] bin_count;
		logic               last_bin;
	} in_item_t;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic             valley_found;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] valley_level;
		logic [RUN_W-1:0]   min_run;
		logic [THR_W-1:0]   default_threshold;
	} cfg_t;

	typedef struct packed {
		logic [BIN_IDX_W-1:0] bin_index;
		logic [CNT8_W-1:0]    valley_length;
		logic [CNT8_W-1:0]    rise_count;
		logic [BIN_IDX_W-1:0] valley_end_bin;
		logic                 search_done;
	} search_t;

endpackage

/* sv/hvts_step.sv */
// Per-bin update of the valley search state and result formation.
// Pure combinational; depends on hvts_pkg.
module hvts_step import hvts_pkg::*; (
	input  cfg_t      cfg,
	input  search_t   cur,
	input  in_item_t  item,
	output search_t   nxt,
	output out_item_t result
);

	logic              rising;
	logic [CNT8_W-1:0] rise_inc;
	search_t           upd;

	// a bin at or above the level, or an empty bin during a rise, is rising
	assign rising = (item.bin_count >= cfg.valley_level) ||
		((item.bin_count == '0) && (cur.rise_count != '0));

	assign rise_inc = (cur.rise_count < CNT8_MAX) ? cur.rise_count + 1'b1 : cur.rise_count;

	// search state update for this bin
	always_comb begin
		upd = cur;
		if (!cur.search_done) begin
			if (rising) begin
				upd.rise_count = rise_inc;
				if (rise_inc > CNT8_W'(cfg.min_run)) begin
					if (cur.valley_length < CNT8_W'(cfg.min_run)) begin
						upd.valley_length = '0;
					end else begin
						upd.search_done = 1'b1;
					end
				end
			end else begin
				upd.valley_end_bin = cur.bin_index;
				upd.valley_length  = (cur.valley_length < CNT8_MAX) ?
					cur.valley_length + 1'b1 : cur.valley_length;
				upd.rise_count     = '0;
			end
		end
		if (cur.bin_index < BIN_IDX_MAX) begin
			upd.bin_index = cur.bin_index + 1'b1;
		end
	end

	// result from the updated state, search cleared after the last bin
	always_comb begin
		if (upd.search_done) begin
			result.threshold    = THR_W'({upd.valley_end_bin, 1'b0});
			result.valley_found = 1'b1;
		end else begin
			result.threshold    = cfg.default_threshold;
			result.valley_found = 1'b0;
		end
		nxt = item.last_bin ? search_t'('0) : upd;
	end

endmodule

/* sv/hvts_out_buf.sv */
// Two-entry result buffer: output register plus skid entry.
// Depends on hvts_pkg.
module hvts_out_buf import hvts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_item,
	output logic      full,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic      head_valid_q;
	logic      skid_valid_q;
	out_item_t head_q;
	out_item_t skid_q;
	logic      pop;

	assign pop       = head_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = head_valid_q;
	assign out_item  = head_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!head_valid_q) begin
				head_valid_q <= push;
			end else if (pop) begin
				head_valid_q <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!head_valid_q || pop) begin
			head_q <= skid_valid_q ? skid_q : push_item;
		end
		if (head_valid_q && !pop && push) begin
			skid_q <= push_item;
		end
	end

	// skid entry only ever fills behind a held head
	a_skid_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> head_valid_q)
		else $error("skid entry valid without head entry");

	// no push into a full buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && skid_valid_q))
		else $error("item pushed into full result buffer");

	// a stalled head keeps its item
	a_head_held: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid_q && out_stall) |=> (head_valid_q && $stable(head_q)))
		else $error("stalled result changed");

	// a push while the head is empty or drains lands in the head
	a_push_to_head: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !skid_valid_q && (!head_valid_q || pop)) |=> (head_q == $past(push_item)))
		else $error("pushed item lost");

endmodule

/* sv/histogram_valley_threshold_search.sv */
// Histogram valley threshold search, top level.
// Depends on hvts_pkg, hvts_step and hvts_out_buf.
//
// Takes one histogram bin per cycle while in_stall is low, in bin order,
// and updates the valley search state in the same cycle. The result of
// the bin marked last_bin is registered into the result buffer as that bin
// is taken, and the search state is cleared for the next histogram. A
// two-entry result buffer lets bins keep flowing while a result is held by
// the consumer; in_stall rises only when both entries hold results.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_data and should change only while no histogram is in progress.
module histogram_valley_threshold_search import hvts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// bin items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	// threshold results
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item
);

	cfg_t      cfg_q;
	search_t   search_q;
	search_t   search_nxt;
	out_item_t step_result;
	logic      in_accept;
	logic      buf_full;

	assign in_stall  = buf_full;
	assign in_accept = in_valid && !buf_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.valley_level      <= VALLEY_LEVEL_RST;
			cfg_q.min_run           <= MIN_RUN_RST;
			cfg_q.default_threshold <= DEFAULT_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VALLEY_LEVEL:      cfg_q.valley_level      <= cfg_data[COUNT_W-1:0];
				REG_MIN_RUN:           cfg_q.min_run           <= cfg_data[RUN_W-1:0];
				REG_DEFAULT_THRESHOLD: cfg_q.default_threshold <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// per-bin search logic
	hvts_step u_step (
		.cfg    (cfg_q),
		.cur    (search_q),
		.item   (in_item),
		.nxt    (search_nxt),
		.result (step_result)
	);

	// search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_q <= '0;
		end else if (in_accept) begin
			search_q <= search_nxt;
		end
	end

	// result buffer
	hvts_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept && in_item.last_bin),
		.push_item (step_result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

/* dv/tb_histogram_valley_threshold_search.sv */
`timescale 1ns / 1ps
// Testbench for histogram_valley_threshold_search: directed and random histograms under several
// register settings, with a scoreboard class that predicts each threshold and checks it.
// Depends on hvts_pkg and the histogram_valley_threshold_search top level.
module tb_histogram_valley_threshold_search import hvts_pkg::*; ();

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// valley search prediction and the thresholds still to come
	class threshold_scoreboard;
		cfg_t        cfg;
		search_t     st;
		out_item_t   thresholds_due[$];
		int unsigned n_bins;
		int unsigned n_histograms;
		int unsigned n_found;
		int unsigned n_errors;

		function new();
			cfg = '{VALLEY_LEVEL_RST, MIN_RUN_RST, DEFAULT_THRESHOLD_RST};
			st = '0;
			n_bins = 0;
			n_histograms = 0;
			n_found = 0;
			n_errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_VALLEY_LEVEL:      cfg.valley_level = data[COUNT_W-1:0];
				REG_MIN_RUN:           cfg.min_run = data[RUN_W-1:0];
				REG_DEFAULT_THRESHOLD: cfg.default_threshold = data[THR_W-1:0];
				default: ;
			endcase
		endfunction

		// advance the search by one accepted bin
		function void note_bin(in_item_t it);
			logic      rising;
			out_item_t res;
			n_bins++;
			if (!st.search_done) begin
				rising = (it.bin_count >= cfg.valley_level) ||
					(it.bin_count == '0 && st.rise_count != '0);
				if (rising) begin
					if (st.rise_count != CNT8_MAX)
						st.rise_count = st.rise_count + 1'b1;
					if (st.rise_count > {1'b0, cfg.min_run}) begin
						// short valley is thrown away, a long one ends the search
						if (st.valley_length < {1'b0, cfg.min_run})
							st.valley_length = '0;
						else
							st.search_done = 1'b1;
					end
				end else begin
					st.valley_end_bin = st.bin_index;
					if (st.valley_length != CNT8_MAX)
						st.valley_length = st.valley_length + 1'b1;
					st.rise_count = '0;
				end
			end
			if (st.bin_index != BIN_IDX_MAX)
				st.bin_index = st.bin_index + 1'b1;
			if (it.last_bin) begin
				res.valley_found = st.search_done;
				res.threshold = st.search_done ? {st.valley_end_bin, 1'b0} :
					cfg.default_threshold;
				thresholds_due.push_back(res);
				n_histograms++;
				st = '0;
			end
		endfunction

		function void check_threshold(out_item_t got);
			out_item_t want;
			if (thresholds_due.size() == 0) begin
				$error("threshold result with none due: threshold=%0d valley_found=%0b",
					got.threshold, got.valley_found);
				n_errors++;
				return;
			end
			want = thresholds_due.pop_front();
			if (got.threshold !== want.threshold) begin
				$error("threshold mismatch: expected %0d, got %0d", want.threshold, got.threshold);
				n_errors++;
			end
			if (got.valley_found !== want.valley_found) begin
				$error("valley_found mismatch: expected %0b, got %0b",
					want.valley_found, got.valley_found);
				n_errors++;
			end
			if (want.valley_found)
				n_found++;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_item = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;

	threshold_scoreboard sb;
	bit          calm = 1'b0;
	int unsigned n_settings = 1;

	histogram_valley_threshold_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random back-pressure on results
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 36);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_threshold(out_item);
	end

	// send one bin and wait until it is taken
	task automatic send_bin(input logic [COUNT_W-1:0] cnt, input logic last);
		while (!calm && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{bin_count: cnt, last_bin: last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_bin('{bin_count: cnt, last_bin: last});
	endtask

	// stop sending and let every due threshold come out
	task automatic drain();
		int unsigned waited;
		in_valid <= 1'b0;
		waited = 0;
		while (sb.thresholds_due.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic apply_setting(input logic [COUNT_W-1:0] lvl, input logic [RUN_W-1:0] run,
			input logic [THR_W-1:0] dflt);
		drain();
		write_reg(REG_VALLEY_LEVEL, lvl);
		write_reg(REG_MIN_RUN, CFG_DATA_W'(run));
		write_reg(REG_DEFAULT_THRESHOLD, CFG_DATA_W'(dflt));
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// bin counts at or above the level, boundary weighted
	function automatic logic [COUNT_W-1:0] rising_count(logic [COUNT_W-1:0] lvl);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 20)
			return lvl;
		if (pick < 30)
			return COUNT_MAX;
		return COUNT_W'($urandom_range(COUNT_MAX, lvl));
	endfunction

	// bin counts below the level, zero and level minus one weighted
	function automatic logic [COUNT_W-1:0] valley_count(logic [COUNT_W-1:0] lvl);
		int unsigned pick;
		pick = $urandom_range(99);
		if (lvl == '0 || pick < 15)
			return '0;
		if (pick < 30)
			return lvl - 1'b1;
		return COUNT_W'($urandom_range(lvl - 1'b1, 0));
	endfunction

	function automatic logic [COUNT_W-1:0] noise_count(logic [COUNT_W-1:0] lvl);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 25)
			return COUNT_W'($urandom);
		if (pick < 40)
			return '0;
		if (pick < 50)
			return COUNT_MAX;
		if (pick < 75)
			return valley_count(lvl);
		return rising_count(lvl);
	endfunction

	// mostly short histograms, some past the bin limit, long ones when min_run is large
	function automatic int unsigned pick_length();
		int unsigned pick;
		pick = $urandom_range(99);
		if (sb.cfg.min_run > 40 && pick < 30)
			return $urandom_range(320, 260);
		if (pick < 2)
			return $urandom_range(300, 260);
		if (pick < 8)
			return $urandom_range(140, 100);
		return $urandom_range(30, 1);
	endfunction

	// rise, a dip of random length near min_run, rise again; a little noise on top
	task automatic send_histogram(input int unsigned len, input bit shaped);
		int unsigned        lead;
		int unsigned        dip;
		int unsigned        pick;
		logic [COUNT_W-1:0] lvl;
		logic [COUNT_W-1:0] cnt;
		lvl = sb.cfg.valley_level;
		lead = $urandom_range(len - 1);
		dip = $urandom_range(2 * sb.cfg.min_run + 2, 1);
		for (int unsigned i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (!shaped || pick < 8)
				cnt = noise_count(lvl);
			else if (i >= lead && i < lead + dip)
				cnt = valley_count(lvl);
			else if (pick < 18)
				cnt = '0;
			else
				cnt = rising_count(lvl);
			send_bin(cnt, i == len - 1);
		end
	endtask

	task automatic random_phase(input int unsigned bin_target);
		while (sb.n_bins < bin_target)
			send_histogram(pick_length(), $urandom_range(99) < 80);
	endtask

	// stimulus
	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// valley of three closed by a rise with a zero inside it, then ignored bins
		send_bin(20'd500, 1'b0);
		send_bin(20'd50, 1'b0);
		send_bin(20'd40, 1'b0);
		send_bin(20'd30, 1'b0);
		send_bin(20'd200, 1'b0);
		send_bin(20'd0, 1'b0);
		send_bin(20'd300, 1'b0);
		send_bin(20'd400, 1'b0);
		send_bin(20'd10, 1'b0);
		send_bin(COUNT_MAX, 1'b1);
		// short valley discarded, default threshold
		send_bin(20'd500, 1'b0);
		send_bin(20'd20, 1'b0);
		send_bin(20'd30, 1'b0);
		send_bin(20'd200, 1'b0);
		send_bin(20'd200, 1'b0);
		send_bin(20'd200, 1'b0);
		send_bin(20'd200, 1'b0);
		send_bin(20'd0, 1'b0);
		send_bin(20'd5, 1'b1);
		// single bin histogram, a zero before any rise counts as valley
		send_bin(20'd0, 1'b1);
		// counts on either side of the level
		send_bin(COUNT_MAX, 1'b0);
		send_bin(20'd99, 1'b0);
		send_bin(20'd100, 1'b0);
		send_bin(20'd0, 1'b0);
		send_bin(20'd99, 1'b1);

		random_phase(260);

		// no idling on either side through this setting
		calm = 1'b1;
		apply_setting(COUNT_MAX, 7'd1, 8'd0);
		random_phase(520);
		calm = 1'b0;

		apply_setting(20'd5000, 7'd127, 8'd255);
		random_phase(800);

		// min_run of zero: the first rise ends the search
		apply_setting(COUNT_W'($urandom_range(4096, 1)), 7'd0, THR_W'($urandom_range(255)));
		random_phase(1050);

		// level of zero: nothing is ever a valley
		apply_setting('0, 7'd5, 8'd200);
		random_phase(1250);

		apply_setting(COUNT_W'($urandom), RUN_W'($urandom_range(127, 1)),
			THR_W'($urandom_range(255)));
		random_phase(1550);

		apply_setting(VALLEY_LEVEL_RST, MIN_RUN_RST, DEFAULT_THRESHOLD_RST);
		random_phase(1800);

		drain();
		repeat (10) @(posedge clk);
		if (sb.thresholds_due.size() != 0) begin
			$error("%0d thresholds never arrived", sb.thresholds_due.size());
			sb.n_errors++;
		end

		$display("covered %0d bins in %0d histograms over %0d register settings",
			sb.n_bins, sb.n_histograms, n_settings);
		$display("valleys found in %0d histograms, %0d errors", sb.n_found, sb.n_errors);
		if (sb.n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
